[sv/ccvp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccvp_pkg
// Shared types, codes and the color name table of the CSS color value parser.
// ----------------------------------------------------------------------------
package ccvp_pkg;

	localparam int NAME_TABLE_ENTRIES = 20;
	localparam int HEX_MAX_DIGITS     = 8;
	localparam int QUEUE_DEPTH        = 4;
	localparam int QUEUE_AW           = $clog2(QUEUE_DEPTH);

	// 2^22/100 rounded up; exact for sums up to 25500
	localparam logic [15:0] LUM_RECIP = 16'd41944;
	localparam int          LUM_SHIFT = 22;

	typedef enum logic [1:0] {
		FORM_HEX  = 2'd0,
		FORM_RGB  = 2'd1,
		FORM_NAME = 2'd2,
		FORM_NONE = 2'd3
	} form_t;

	typedef enum logic [1:0] {
		REG_LIFT_ENABLE      = 2'd0,
		REG_LIFT_THRESHOLD   = 2'd1,
		REG_LIFT_TARGET      = 2'd2,
		REG_DARK_REPLACEMENT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic        enable;
		logic [7:0]  threshold;
		logic [7:0]  target;
		logic [23:0] replacement;
	} lift_cfg_t;

	typedef struct packed {
		logic        valid;
		logic [23:0] rgb;
		form_t       form;
	} color_item_t;

	localparam logic [63:0] NAME_TXT [NAME_TABLE_ENTRIES] = '{
		"black", "white", "red", "green", "blue", "yellow", "orange", "purple",
		"gray", "grey", "silver", "maroon", "navy", "teal", "olive", "lime",
		"aqua", "cyan", "fuchsia", "magenta"
	};

	localparam logic [3:0] NAME_LEN [NAME_TABLE_ENTRIES] = '{
		4'd5, 4'd5, 4'd3, 4'd5, 4'd4, 4'd6, 4'd6, 4'd6, 4'd4, 4'd4,
		4'd6, 4'd6, 4'd4, 4'd4, 4'd5, 4'd4, 4'd4, 4'd4, 4'd7, 4'd7
	};

	localparam logic [23:0] NAME_RGB [NAME_TABLE_ENTRIES] = '{
		24'h000000, 24'hFFFFFF, 24'hE06060, 24'h4CC38A, 24'h6FB5F0,
		24'hF5C542, 24'hE0A036, 24'hB08CE8, 24'h8A97A7, 24'h8A97A7,
		24'hC0C8D0, 24'hC05050, 24'h5070C0, 24'h40B0B0, 24'hA0A050,
		24'h70E070, 24'h70E0E0, 24'h70E0E0, 24'hE070E0, 24'hE070E0
	};

	// character p (from the left) of table entry k; literals are right aligned
	function automatic logic [7:0] name_char(input int k, input logic [2:0] p);
		logic [3:0] lsb_ch;
		lsb_ch = NAME_LEN[k] - 4'd1 - {1'b0, p};
		return NAME_TXT[k][{lsb_ch[2:0], 3'b000} +: 8];
	endfunction

endpackage

[sv/ccvp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccvp_char_if / ccvp_color_if
// Valid/ready channels for input characters and color results.
// ----------------------------------------------------------------------------
interface ccvp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface ccvp_color_if;
	logic        valid;
	logic        ready;
	logic        color_valid;
	logic [23:0] color_rgb;
	logic [1:0]  form_kind;

	modport source (output valid, output color_valid, output color_rgb,
		output form_kind, input ready);
	modport sink   (input valid, input color_valid, input color_rgb,
		input form_kind, output ready);
endinterface

[sv/css_color_value_parser.sv]
`timescale 1ns / 1ps
// The parser takes one character per cycle while the 4-entry queue is not full;
// the queue absorbs bursts of short values. The lift unit runs each value
// through S_IDLE, S_LUM, S_DEC and S_OUT (lifted colors also S_DIV, the scale
// divider, and S_MUL) and takes the next one after the output has accepted it.
// Reset (arst_n low) clears parser state, queue and lift unit, and loads
// the lift registers with their defaults.
// ----------------------------------------------------------------------------
// css_color_value_parser
// CSS color value parser (hex, rgb(), named) with dark-color lifting.
// ----------------------------------------------------------------------------
module css_color_value_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [23:0]         cfg_data,
	ccvp_char_if.sink           char_in,
	ccvp_color_if.source        color_out
);
	import ccvp_pkg::*;

	lift_cfg_t   cfg_q;
	logic        push, full, pop, nonempty;
	color_item_t push_item, head, out_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable      <= 1'b1;
			cfg_q.threshold   <= 8'd90;
			cfg_q.target      <= 8'd120;
			cfg_q.replacement <= 24'hD6DDE6;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_LIFT_ENABLE:      cfg_q.enable      <= cfg_data[0];
				REG_LIFT_THRESHOLD:   cfg_q.threshold   <= cfg_data[7:0];
				REG_LIFT_TARGET:      cfg_q.target      <= cfg_data[7:0];
				REG_DARK_REPLACEMENT: cfg_q.replacement <= cfg_data;
				default: ;
			endcase
		end
	end

	ccvp_front u_front (
		.clk, .arst_n,
		.in_valid  (char_in.valid),
		.in_ready  (char_in.ready),
		.char_code (char_in.char_code),
		.last_char (char_in.last_char),
		.push, .push_item, .full
	);

	ccvp_queue u_queue (
		.clk, .arst_n, .push, .push_item, .full, .pop, .nonempty, .head
	);

	ccvp_back u_back (
		.clk, .arst_n,
		.cfg       (cfg_q),
		.nonempty, .head, .pop,
		.out_valid (color_out.valid),
		.out_ready (color_out.ready),
		.out_item
	);

	assign color_out.color_valid = out_item.valid;
	assign color_out.color_rgb   = out_item.rgb;
	assign color_out.form_kind   = out_item.form;

endmodule

[sv/ccvp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccvp_front
// Character parser: one character per cycle while full is low, emits a parsed color per value.
// ----------------------------------------------------------------------------
module ccvp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            char_code,
	input  logic                  last_char,
	output logic                  push,
	output ccvp_pkg::color_item_t push_item,
	input  logic                  full
);
	import ccvp_pkg::*;

	typedef enum logic [2:0] {
		M_SPACE, M_HEX, M_WORD, M_PAREN, M_SEP, M_DIGIT, M_DONE, M_FAIL
	} mode_t;

	mode_t                         mode_q, n_mode;
	logic [23:0]                   hex_digits_q, n_hex_digits;
	logic [3:0]                    hex_count_q, n_hex_count;
	logic [1:0]                    comp_idx_q, n_comp_idx;
	logic [7:0]                    accum_q, n_accum;
	logic [23:0]                   comps_q, n_comps;
	logic [NAME_TABLE_ENTRIES-1:0] cand_q, n_cand;
	logic [2:0]                    pos_q, n_pos;
	logic [23:0]                   match_q, n_match;
	form_t                         form_q, n_form;
	logic                          alive_q, n_alive;

	logic        fire;
	logic [7:0]  lc;
	logic        blank, is_digit;
	logic [4:0]  hexv;
	logic [11:0] acc_wide;
	logic        do_word, hit;
	logic [23:0] hit_rgb;
	logic [23:0] hex_rgb;
	logic        hex_ok;
	logic [24:0] end_hex;
	mode_t       f_mode;
	logic [23:0] f_match;
	form_t       f_form;

	assign in_ready = !full;
	assign fire     = in_valid && in_ready;

	function automatic logic [24:0] close_hex(input logic [23:0] d, input logic [3:0] n);
		logic [11:0] t;
		if (n >= 4'd6) begin
			return {1'b1, d};
		end
		t = (n == 4'd5) ? d[19:8] : (n == 4'd4) ? d[15:4] : d[11:0];
		return {(n >= 4'd3), t[11:8], t[11:8], t[7:4], t[7:4], t[3:0], t[3:0]};
	endfunction

	always_comb begin
		lc       = (char_code inside {[8'h41:8'h5A]}) ? char_code + 8'd32 : char_code;
		blank    = char_code inside {8'd32, 8'd9, 8'd13, 8'd10, 8'd12};
		is_digit = char_code inside {[8'h30:8'h39]};
		if (is_digit) hexv = {1'b1, char_code[3:0]};
		else if (lc inside {[8'h61:8'h66]}) hexv = {1'b1, lc[3:0] + 4'd9};
		else hexv = 5'd0;
	end

	always_comb begin
		n_mode = mode_q; n_hex_digits = hex_digits_q; n_hex_count = hex_count_q;
		n_comp_idx = comp_idx_q; n_accum = accum_q; n_comps = comps_q;
		n_cand = cand_q; n_pos = pos_q; n_match = match_q; n_form = form_q;
		n_alive = alive_q;
		do_word = 1'b0; hit = 1'b0; hit_rgb = '0;
		acc_wide = {4'd0, accum_q} * 12'd10 + {8'd0, char_code[3:0]};
		{hex_ok, hex_rgb} = close_hex(hex_digits_q, hex_count_q);
		case (mode_q)
			M_SPACE: begin
				if (char_code == 8'h23) n_mode = M_HEX;
				else if (!blank) do_word = 1'b1;
			end
			M_HEX: begin
				if (hexv[4] && hex_count_q < 4'(HEX_MAX_DIGITS)) begin
					if (hex_count_q < 4'd6) n_hex_digits = {hex_digits_q[19:0], hexv[3:0]};
					n_hex_count = hex_count_q + 4'd1;
				end else if (hex_ok) begin
					n_mode = M_DONE; n_match = hex_rgb; n_form = FORM_HEX;
				end else begin
					n_mode = M_FAIL;
				end
			end
			M_WORD: do_word = 1'b1;
			M_PAREN: if (char_code == 8'h28) n_mode = M_SEP;
			M_SEP: begin
				if (is_digit) begin
					n_accum = {4'd0, char_code[3:0]}; n_mode = M_DIGIT;
				end else if (!(blank || char_code == 8'h2C)) begin
					n_mode = M_FAIL;
				end
			end
			M_DIGIT: begin
				if (is_digit) begin
					n_accum = (acc_wide > 12'd255) ? 8'd255 : acc_wide[7:0];
				end else begin
					n_comps = {comps_q[15:0], accum_q};
					if (comp_idx_q >= 2'd2) begin
						n_mode = M_DONE; n_match = {comps_q[15:0], accum_q}; n_form = FORM_RGB;
					end else if (blank || char_code == 8'h2C) begin
						n_comp_idx = comp_idx_q + 2'd1; n_mode = M_SEP;
					end else begin
						n_mode = M_FAIL;
					end
				end
			end
			default: ;
		endcase

		if (do_word) begin
			n_mode  = M_WORD;
			n_alive = alive_q && pos_q < 3'd3 &&
				lc == ((pos_q == 3'd0) ? 8'h72 : (pos_q == 3'd1) ? 8'h67 : 8'h62);
			if (n_alive && pos_q == 3'd2) begin
				n_mode = M_PAREN; n_comp_idx = 2'd0;
			end else begin
				for (int k = 0; k < NAME_TABLE_ENTRIES; k++) begin
					if (cand_q[k] && ({1'b0, pos_q} >= NAME_LEN[k] || lc != name_char(k, pos_q)))
						n_cand[k] = 1'b0;
				end
				// lowest entry wins
				for (int k = NAME_TABLE_ENTRIES - 1; k >= 0; k--) begin
					if (n_cand[k] && NAME_LEN[k] == {1'b0, pos_q} + 4'd1) begin
						hit = 1'b1; hit_rgb = NAME_RGB[k];
					end
				end
				if (hit) begin
					n_mode = M_DONE; n_match = hit_rgb; n_form = FORM_NAME;
				end else begin
					if (n_cand == '0 && !n_alive) n_mode = M_FAIL;
					if (pos_q < 3'd7) n_pos = pos_q + 3'd1;
				end
			end
		end
	end

	// end of value: close an open hex run or a third component
	always_comb begin
		f_mode = n_mode; f_match = n_match; f_form = n_form;
		end_hex = close_hex(n_hex_digits, n_hex_count);
		if (n_mode == M_HEX) begin
			if (end_hex[24]) begin
				f_mode = M_DONE; f_match = end_hex[23:0];
				f_form = FORM_HEX;
			end else begin
				f_mode = M_FAIL;
			end
		end
		if (n_mode == M_DIGIT && n_comp_idx >= 2'd2) begin
			f_mode = M_DONE; f_match = {n_comps[15:0], n_accum}; f_form = FORM_RGB;
		end
		push_item.valid = (f_mode == M_DONE);
		push_item.rgb   = (f_mode == M_DONE) ? f_match : 24'd0;
		push_item.form  = (f_mode == M_DONE) ? f_form : FORM_NONE;
	end

	assign push = fire && last_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_SPACE; hex_digits_q <= '0; hex_count_q <= '0; comp_idx_q <= '0;
			accum_q <= '0; comps_q <= '0; cand_q <= '1; pos_q <= '0; match_q <= '0;
			form_q <= FORM_NONE; alive_q <= 1'b1;
		end else if (fire && last_char) begin
			mode_q <= M_SPACE; hex_digits_q <= '0; hex_count_q <= '0; comp_idx_q <= '0;
			accum_q <= '0; comps_q <= '0; cand_q <= '1; pos_q <= '0; match_q <= '0;
			form_q <= FORM_NONE; alive_q <= 1'b1;
		end else if (fire) begin
			mode_q <= n_mode; hex_digits_q <= n_hex_digits; hex_count_q <= n_hex_count;
			comp_idx_q <= n_comp_idx; accum_q <= n_accum; comps_q <= n_comps;
			cand_q <= n_cand; pos_q <= n_pos; match_q <= n_match; form_q <= n_form;
			alive_q <= n_alive;
		end
	end

endmodule

[sv/ccvp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccvp_queue
// Small FIFO of parsed colors between the parser and the lift unit.
// ----------------------------------------------------------------------------
module ccvp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ccvp_pkg::color_item_t push_item,
	output logic                  full,
	input  logic                  pop,
	output logic                  nonempty,
	output ccvp_pkg::color_item_t head
);
	import ccvp_pkg::*;

	color_item_t           mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_q, rd_q;
	logic [QUEUE_AW:0]     cnt_q;

	assign full     = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
		end
	end

endmodule

[sv/ccvp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccvp_back
// Dark-color lift: luminance, iterative scale division, channel scaling, zero-luminance replacement.
// ----------------------------------------------------------------------------
module ccvp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ccvp_pkg::lift_cfg_t   cfg,
	input  logic                  nonempty,
	input  ccvp_pkg::color_item_t head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ccvp_pkg::color_item_t out_item
);
	import ccvp_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_LUM, S_DEC, S_DIV, S_MUL, S_OUT} state_t;

	state_t      state_q;
	color_item_t item_q;
	logic [14:0] sum_q;
	logic [7:0]  lum_q;
	logic [15:0] dq_q;
	logic [8:0]  rem_q;
	logic [3:0]  bit_q;

	logic [14:0] sum_c;
	logic [30:0] lum_prod;
	logic [8:0]  rem_sh;
	logic        take;
	logic [23:0] pr, pg, pb;

	assign pop       = (state_q == S_IDLE) && nonempty;
	assign out_valid = (state_q == S_OUT);
	assign out_item  = item_q;

	assign sum_c    = 15'd30 * {7'd0, head.rgb[23:16]} + 15'd59 * {7'd0, head.rgb[15:8]}
		+ 15'd11 * {7'd0, head.rgb[7:0]};
	assign lum_prod = {16'd0, sum_q} * {15'd0, LUM_RECIP};
	assign rem_sh   = {rem_q[7:0], dq_q[15]};
	assign take     = rem_sh >= {1'b0, lum_q};
	assign pr       = {16'd0, item_q.rgb[23:16]} * {8'd0, dq_q};
	assign pg       = {16'd0, item_q.rgb[15:8]} * {8'd0, dq_q};
	assign pb       = {16'd0, item_q.rgb[7:0]} * {8'd0, dq_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			item_q  <= '0;
			sum_q   <= '0; lum_q <= '0; dq_q <= '0; rem_q <= '0; bit_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (nonempty) begin
						item_q  <= head;
						sum_q   <= sum_c;
						state_q <= S_LUM;
					end
				end
				S_LUM: begin
					lum_q   <= lum_prod[LUM_SHIFT +: 8];
					state_q <= S_DEC;
				end
				S_DEC: begin
					if (!item_q.valid || !cfg.enable || lum_q >= cfg.threshold) begin
						state_q <= S_OUT;
					end else if (lum_q == 8'd0) begin
						item_q.rgb <= cfg.replacement;
						state_q    <= S_OUT;
					end else begin
						dq_q    <= {cfg.target, 8'd0};
						rem_q   <= '0;
						bit_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// one quotient bit per cycle
					rem_q <= take ? rem_sh - {1'b0, lum_q} : rem_sh;
					dq_q  <= {dq_q[14:0], take};
					bit_q <= bit_q + 4'd1;
					if (bit_q == 4'd15) state_q <= S_MUL;
				end
				S_MUL: begin
					item_q.rgb <= {(pr[23:16] != 8'd0) ? 8'd255 : pr[15:8],
						(pg[23:16] != 8'd0) ? 8'd255 : pg[15:8],
						(pb[23:16] != 8'd0) ? 8'd255 : pb[15:8]};
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[sv/ccvp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccvp_checker
// Port-level checks on the color result channel.
// ----------------------------------------------------------------------------
module ccvp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        color_valid,
	input logic [23:0] color_rgb,
	input logic [1:0]  form_kind
);
	import ccvp_pkg::*;

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !color_valid |-> color_rgb == 24'd0 && form_kind == FORM_NONE)
		else $error("unrecognized value carries color data");

	a_valid_has_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && color_valid |-> form_kind != FORM_NONE)
		else $error("recognized color without a form");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(color_rgb) && $stable(form_kind))
		else $error("result beat dropped or changed while stalled");

endmodule

bind css_color_value_parser ccvp_checker u_ccvp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (color_out.valid),
	.out_ready   (color_out.ready),
	.color_valid (color_out.color_valid),
	.color_rgb   (color_out.color_rgb),
	.form_kind   (color_out.form_kind)
);
